FILE: design/tga_rle_pixel_decoder_defines.svh
// Assertion helpers shared by the decoder files.
// Every check is clocked on clk and held off while rst is high.
`ifndef TGA_RLE_PIXEL_DECODER_DEFINES_SVH
`define TGA_RLE_PIXEL_DECODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TRD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TRD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/tga_rle_pkg.sv
package tga_rle_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RLE_MODE    = 2'd0;
  localparam logic [1:0] CFG_TEXEL_BYTES = 2'd1;
  localparam logic [1:0] CFG_PIXEL_TOTAL = 2'd2;

  // Fields of an RLE packet header byte.
  localparam logic [7:0] COUNT_MASK = 8'h7F;
  localparam logic [7:0] KIND_BIT   = 8'h80;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_REPEAT  = 2'd1,
    PH_LITERAL = 2'd2
  } phase_t;

  typedef enum logic {
    SEQ_IDLE = 1'b0,
    SEQ_EMIT = 1'b1
  } seq_state_t;

  // Status from the pixel count unit.
  typedef struct packed {
    logic       complete;  // pixels_done has reached pixel_total
    logic       last_hit;  // adding step pixels completes the image
    logic       run_over;  // the repeat run is longer than what is left
    logic [7:0] run_emit;  // pixels of the repeat run that still fit
  } cnt_status_t;

endpackage

FILE: design/tga_rle_count_unit.sv
module tga_rle_count_unit (
  input  logic [31:0]               done,
  input  logic [31:0]               total,
  input  logic [1:0]                step,
  input  logic [7:0]                run_len,
  output logic [31:0]               done_next,
  output tga_rle_pkg::cnt_status_t  status
);

  logic [32:0] diff;
  logic [31:0] avail;
  logic        avail_small;

  // One subtract gives both the completion test and the pixels still missing.
  assign diff        = {1'b0, total} - {1'b0, done};
  assign avail       = diff[31:0];
  assign avail_small = (avail[31:8] == 24'd0);

  assign done_next = done + {30'd0, step};

  always_comb begin
    status.complete = diff[32] || (avail == 32'd0);
    status.last_hit = (avail == {30'd0, step});
    status.run_over = avail_small && (avail[7:0] < run_len);
    status.run_emit = status.run_over ? avail[7:0] : run_len;
  end

endmodule

FILE: design/tga_rle_pixel_decoder.sv
// TGA true-color pixel data decoder.
// Input: s_axis carries one pixel-data byte per transfer (tdata[7:0]).
// Output: m_axis carries one or two pixels per transfer. tdata holds
// pixel_first in [31:0], pixel_second in [63:32] and pixel_count in [65:64];
// tlast marks the transfer with the image's final pixel and tuser flags an
// overrun (pixels of the current packet beyond pixel_total were dropped).
// Configuration: cfg_index selects rle_mode (0), texel_bytes (1) or
// pixel_total (2); writes are taken every cycle and belong to idle time.
// Timing: a texel that completes a raw or literal pixel is presented on
// m_axis in the following cycle. A repeat packet is expanded by the
// sequencer at up to two pixels per output transfer, stalling while the
// receiver is not ready; after its texel's last byte s_axis_tready stays
// low until the run is done; one pixel count unit (subtract and add on the
// 32-bit pixel counter) serves both the byte and the emit cycles.
// A single output register parts the two sides: a new byte is taken while a
// result waits only if that result is being taken in the same cycle, so a
// stalled receiver holds the decoder after at most one pending result.
// Once the image is complete every further byte is taken and dropped.
// Reset (rst, synchronous) restores rle_mode 1, texel_bytes 4, pixel_total 1
// and clears the packet state, the texel gather and the pixel counter.
`include "tga_rle_pixel_decoder_defines.svh"

module tga_rle_pixel_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // pixel_first, pixel_second, pixel_count, zero pad
  output logic        m_axis_tlast,   // last_of_image
  output logic        m_axis_tuser,   // overrun
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Configuration registers.
  logic        rle_mode;
  logic [2:0]  texel_bytes;
  logic [31:0] pixel_total;

  // Decoder state.
  tga_rle_pkg::seq_state_t state, state_next;
  tga_rle_pkg::phase_t     phase, phase_next;
  logic [7:0]  packet_left, packet_left_next;
  logic [1:0]  byte_pos, byte_pos_next;
  logic [31:0] texel, texel_next;
  logic [31:0] pixels_done, pixels_done_next;
  logic [7:0]  emit_left, emit_left_next;
  logic        run_ovr, run_ovr_next;

  // Output register.
  logic        m_valid;
  logic [31:0] out_first, out_first_next;
  logic [31:0] out_second, out_second_next;
  logic [1:0]  out_count, out_count_next;
  logic        out_last, out_last_next;
  logic        out_ovr, out_ovr_next;
  logic        load_out;

  // Control.
  logic        out_free;
  logic        in_xfer;
  logic        take;
  logic        rle_header;
  logic [1:0]  texel_top;
  logic        texel_done;
  logic [31:0] gather_new;
  logic [1:0]  emit_c;
  logic        emit_final;
  logic [1:0]  step;
  logic        start_run;
  logic [31:0] cnt_done_next;
  tga_rle_pkg::cnt_status_t cnt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rle_mode    <= 1'b1;
      texel_bytes <= 3'd4;
      pixel_total <= 32'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tga_rle_pkg::CFG_RLE_MODE:    rle_mode    <= cfg_data[0];
        tga_rle_pkg::CFG_TEXEL_BYTES: texel_bytes <= cfg_data[2:0];
        tga_rle_pkg::CFG_PIXEL_TOTAL: pixel_total <= cfg_data;
        default: ;
      endcase
    end
  end

  tga_rle_count_unit u_count (
    .done      (pixels_done),
    .total     (pixel_total),
    .step      (step),
    .run_len   (packet_left),
    .done_next (cnt_done_next),
    .status    (cnt)
  );

  // Handshake and texel gathering.
  assign out_free      = !m_valid || m_axis_tready;
  assign s_axis_tready = (state == tga_rle_pkg::SEQ_IDLE) && out_free;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign take          = in_xfer && !cnt.complete;
  assign rle_header    = rle_mode && (phase != tga_rle_pkg::PH_REPEAT) &&
                         (phase != tga_rle_pkg::PH_LITERAL);
  assign texel_top     = (texel_bytes == 3'd3) ? 2'd2 : 2'd3;
  assign texel_done    = (byte_pos >= texel_top);
  assign gather_new    = ((byte_pos == 2'd0) ? 32'd0 : texel) |
                         ({24'd0, s_axis_tdata} << {byte_pos, 3'b000});
  assign emit_c        = (emit_left >= 8'd2) ? 2'd2 : 2'd1;
  assign emit_final    = (emit_left == {6'd0, emit_c});
  assign step          = (state == tga_rle_pkg::SEQ_EMIT) ? emit_c : 2'd1;

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      tga_rle_pkg::SEQ_IDLE: begin
        if (start_run) state_next = tga_rle_pkg::SEQ_EMIT;
      end
      tga_rle_pkg::SEQ_EMIT: begin
        if (out_free && emit_final) state_next = tga_rle_pkg::SEQ_IDLE;
      end
      default: state_next = tga_rle_pkg::SEQ_IDLE;
    endcase
  end

  // Datapath updates and result formation.
  always_comb begin
    phase_next       = phase;
    packet_left_next = packet_left;
    byte_pos_next    = byte_pos;
    texel_next       = texel;
    pixels_done_next = pixels_done;
    emit_left_next   = emit_left;
    run_ovr_next     = run_ovr;
    start_run        = 1'b0;
    load_out         = 1'b0;
    out_first_next   = out_first;
    out_second_next  = out_second;
    out_count_next   = out_count;
    out_last_next    = out_last;
    out_ovr_next     = out_ovr;
    case (state)
      tga_rle_pkg::SEQ_IDLE: begin
        if (take && rle_header) begin
          packet_left_next = {1'b0, s_axis_tdata[6:0] & tga_rle_pkg::COUNT_MASK[6:0]} + 8'd1;
          phase_next = ((s_axis_tdata & tga_rle_pkg::KIND_BIT) != 8'd0) ?
                       tga_rle_pkg::PH_REPEAT : tga_rle_pkg::PH_LITERAL;
          byte_pos_next = 2'd0;
          texel_next    = 32'd0;
        end else if (take) begin
          texel_next    = gather_new;
          byte_pos_next = texel_done ? 2'd0 : byte_pos + 2'd1;
          if (texel_done) begin
            if (!rle_mode) begin
              pixels_done_next = cnt_done_next;
              load_out         = 1'b1;
              out_first_next   = gather_new;
              out_second_next  = 32'd0;
              out_count_next   = 2'd1;
              out_last_next    = cnt.last_hit;
              out_ovr_next     = 1'b0;
            end else if (phase == tga_rle_pkg::PH_REPEAT) begin
              // The whole run is sized here; the emit cycles only count down.
              start_run        = 1'b1;
              emit_left_next   = cnt.run_emit;
              run_ovr_next     = cnt.run_over;
              packet_left_next = 8'd0;
              phase_next       = tga_rle_pkg::PH_HEADER;
            end else begin
              pixels_done_next = cnt_done_next;
              packet_left_next = packet_left - 8'd1;
              if (packet_left_next == 8'd0) phase_next = tga_rle_pkg::PH_HEADER;
              load_out        = 1'b1;
              out_first_next  = gather_new;
              out_second_next = 32'd0;
              out_count_next  = 2'd1;
              out_last_next   = cnt.last_hit;
              out_ovr_next    = cnt.last_hit && (packet_left_next != 8'd0);
            end
          end
        end
      end
      tga_rle_pkg::SEQ_EMIT: begin
        if (out_free) begin
          pixels_done_next = cnt_done_next;
          emit_left_next   = emit_left - {6'd0, emit_c};
          load_out         = 1'b1;
          out_first_next   = texel;
          out_second_next  = (emit_c == 2'd2) ? texel : 32'd0;
          out_count_next   = emit_c;
          out_last_next    = cnt.last_hit;
          out_ovr_next     = emit_final && run_ovr;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= tga_rle_pkg::SEQ_IDLE;
      phase       <= tga_rle_pkg::PH_HEADER;
      packet_left <= 8'd0;
      byte_pos    <= 2'd0;
      texel       <= 32'd0;
      pixels_done <= 32'd0;
      emit_left   <= 8'd0;
      run_ovr     <= 1'b0;
      m_valid     <= 1'b0;
    end else begin
      state       <= state_next;
      phase       <= phase_next;
      packet_left <= packet_left_next;
      byte_pos    <= byte_pos_next;
      texel       <= texel_next;
      pixels_done <= pixels_done_next;
      emit_left   <= emit_left_next;
      run_ovr     <= run_ovr_next;
      if (load_out) m_valid <= 1'b1;
      else if (m_axis_tready) m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_first  <= out_first_next;
    out_second <= out_second_next;
    out_count  <= out_count_next;
    out_last   <= out_last_next;
    out_ovr    <= out_ovr_next;
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {6'd0, out_count, out_second, out_first};
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_ovr;

  // A run being expanded always has pixels left to send.
  `TRD_ASSERT_IMP(a_emit_nonzero, state == tga_rle_pkg::SEQ_EMIT, emit_left != 8'd0, "empty run in emit")
  // No byte is taken while a run is being expanded.
  `TRD_ASSERT_IMP(a_no_input_in_emit, state == tga_rle_pkg::SEQ_EMIT, !s_axis_tready, "byte taken during run")
  // Every result carries one or two pixels.
  `TRD_ASSERT_IMP(a_count_range, m_valid, out_count == 2'd1 || out_count == 2'd2, "bad pixel count")
  // A two-pixel result only comes from a repeat run, so both pixels match.
  `TRD_ASSERT_IMP(a_pair_equal, m_valid && out_count == 2'd2, out_second == out_first, "pair mismatch")
  // The final pixel of a run returns the sequencer to accepting bytes.
  `TRD_ASSERT_NXT(a_run_ends, state == tga_rle_pkg::SEQ_EMIT && out_free && emit_final, state == tga_rle_pkg::SEQ_IDLE, "run did not end")

endmodule
